// ===== design/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// Text console writer package
// Shared codes, constants and the cell store request type.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int CELL_W = 16;
   localparam int ADDR_W = 14;

   localparam logic [7:0]        NEWLINE_CH = 8'h0A;
   localparam logic [7:0]        BLANK_CH   = 8'h20;
   localparam logic [CELL_W-1:0] RESET_CELL = 16'h0F20;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_READ  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_INIT   = 6'b000010,
      ST_SCROLL = 6'b000100,
      ST_DRAIN  = 6'b001000,
      ST_FILL   = 6'b010000,
      ST_RESP   = 6'b100000
   } state_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [CELL_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } ram_req_type;

endpackage

// ===== design/tcw_cell_ram.sv =====
// ----------------------------------------------------------------------------
// Text console cell store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_cell_ram #(
   parameter int DEPTH = 2000
) (
   input  logic                       clock,
   input  tcw_pkg::ram_req_type       req,
   output logic [tcw_pkg::CELL_W-1:0] rdata
);

   localparam int AW = $clog2(DEPTH);

   logic [tcw_pkg::CELL_W-1:0] mem [DEPTH];
   logic [tcw_pkg::CELL_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr[AW-1:0]] <= req.wr_data;
      end
      if (req.rd_en) begin
         rdata_ff <= mem[req.rd_addr[AW-1:0]];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/text_console_writer_core.sv =====
// ----------------------------------------------------------------------------
// Text console writer core
// Character-cell console of ROWS by COLS cells with cursor, scroll and clear.
// ----------------------------------------------------------------------------
// After reset a clearing pass fills the cell store with white blanks, and no
// item is accepted until it ends. A write, newline, read or unused command
// loads the result register once that register is free. A clear fills every
// cell first, and a write or newline that scrolls first moves each row up and
// blanks the last row, because the sequencer moves one cell per cycle through
// the single write port of the cell store. The next item is accepted while a
// finished result still waits to be taken.
module text_console_writer_core #(
   parameter int COLS = 80,
   parameter int ROWS = 25
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // ch, read_row, read_col
   input  logic [1:0]  req_tuser,  // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // cell_data, cursor_col, cursor_row, cursor_offset, scrolled
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [3:0]  csr_wdata
);

   localparam int NCELLS = ROWS * COLS;
   localparam int CW     = $clog2(COLS);
   localparam int RW     = $clog2(ROWS);
   localparam int AW     = $clog2(NCELLS);

   localparam logic [CW-1:0] LAST_COL  = CW'(COLS - 1);
   localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
   localparam logic [AW-1:0] LAST_CELL = AW'(NCELLS - 1);
   localparam logic [AW-1:0] LAST_BASE = AW'(NCELLS - COLS);
   localparam logic [AW-1:0] COLS_A    = AW'(COLS);

   tcw_pkg::state_type state_ff, state_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [AW-1:0] off_ff, off_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] dst_ff, dst_in;
   logic          pend_ff, pend_in;
   logic [15:0]   fill_ff, fill_in;
   logic          scrolled_ff, scrolled_in;
   logic          hit_ff, hit_in;
   logic [3:0]    fg_ff, bg_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [47:0]   rsp_data_ff, rsp_data_in;

   tcw_pkg::ram_req_type       ram_req;
   logic [tcw_pkg::CELL_W-1:0] ram_rdata;

   tcw_pkg::cmd_type cmd;
   logic [7:0]  ch;
   logic [5:0]  read_row;
   logic [7:0]  read_col;
   logic [7:0]  attr;
   logic        accept;
   logic        in_range;
   logic [14:0] read_addr;
   logic [15:0] cell_out;

   assign cmd      = tcw_pkg::cmd_type'(req_tuser);
   assign ch       = req_tdata[7:0];
   assign read_row = req_tdata[13:8];
   assign read_col = req_tdata[21:14];
   assign attr     = {bg_ff, fg_ff};

   assign req_tready = (state_ff == tcw_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign in_range   = ({1'b0, read_row} < 7'(ROWS)) && ({1'b0, read_col} < 9'(COLS));
   assign read_addr  = 15'(read_row * COLS) + 15'(read_col);
   assign cell_out   = hit_ff ? ram_rdata : 16'h0000;

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      off_in       = off_ff;
      cnt_in       = cnt_ff;
      dst_in       = dst_ff;
      pend_in      = pend_ff;
      fill_in      = fill_ff;
      scrolled_in  = scrolled_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      ram_req      = '0;

      unique case (state_ff)
         tcw_pkg::ST_IDLE: begin
            if (accept) begin
               scrolled_in = 1'b0;
               hit_in      = 1'b0;
               state_in    = tcw_pkg::ST_RESP;
               unique case (cmd)
                  tcw_pkg::CMD_WRITE: begin
                     if (ch != tcw_pkg::NEWLINE_CH) begin
                        ram_req.wr_en   = 1'b1;
                        ram_req.wr_addr = tcw_pkg::ADDR_W'(off_ff);
                        ram_req.wr_data = {attr, ch};
                     end
                     if (ch == tcw_pkg::NEWLINE_CH || col_ff == LAST_COL) begin
                        col_in = '0;
                        if (row_ff == LAST_ROW) begin
                           off_in      = LAST_BASE;
                           scrolled_in = 1'b1;
                           cnt_in      = COLS_A;
                           pend_in     = 1'b0;
                           state_in    = tcw_pkg::ST_SCROLL;
                        end else begin
                           row_in = row_ff + 1'b1;
                           off_in = AW'(off_ff - AW'(col_ff) + COLS_A);
                        end
                     end else begin
                        col_in = col_ff + 1'b1;
                        off_in = off_ff + 1'b1;
                     end
                  end
                  tcw_pkg::CMD_CLEAR: begin
                     col_in   = '0;
                     row_in   = '0;
                     off_in   = '0;
                     cnt_in   = '0;
                     fill_in  = {attr, tcw_pkg::BLANK_CH};
                     state_in = tcw_pkg::ST_FILL;
                  end
                  tcw_pkg::CMD_READ: begin
                     hit_in          = in_range;
                     ram_req.rd_en   = in_range;
                     ram_req.rd_addr = tcw_pkg::ADDR_W'(read_addr);
                  end
                  tcw_pkg::CMD_NONE: begin
                  end
                  default: begin
                  end
               endcase
            end
         end
         tcw_pkg::ST_INIT: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = tcw_pkg::ADDR_W'(cnt_ff);
            ram_req.wr_data = tcw_pkg::RESET_CELL;
            cnt_in          = cnt_ff + 1'b1;
            if (cnt_ff == LAST_CELL) begin
               state_in = tcw_pkg::ST_IDLE;
            end
         end
         tcw_pkg::ST_SCROLL: begin
            ram_req.wr_en   = pend_ff;
            ram_req.wr_addr = tcw_pkg::ADDR_W'(dst_ff);
            ram_req.wr_data = ram_rdata;
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = tcw_pkg::ADDR_W'(cnt_ff);
            pend_in         = 1'b1;
            dst_in          = AW'(cnt_ff - COLS_A);
            cnt_in          = cnt_ff + 1'b1;
            if (cnt_ff == LAST_CELL) begin
               state_in = tcw_pkg::ST_DRAIN;
            end
         end
         tcw_pkg::ST_DRAIN: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = tcw_pkg::ADDR_W'(dst_ff);
            ram_req.wr_data = ram_rdata;
            pend_in         = 1'b0;
            cnt_in          = LAST_BASE;
            fill_in         = {attr, tcw_pkg::BLANK_CH};
            state_in        = tcw_pkg::ST_FILL;
         end
         tcw_pkg::ST_FILL: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = tcw_pkg::ADDR_W'(cnt_ff);
            ram_req.wr_data = fill_ff;
            cnt_in          = cnt_ff + 1'b1;
            if (cnt_ff == LAST_CELL) begin
               state_in = tcw_pkg::ST_RESP;
            end
         end
         tcw_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'b000, scrolled_ff, 14'(off_ff), 6'(row_ff), 8'(col_ff),
                               cell_out};
               state_in     = tcw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tcw_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcw_pkg::ST_INIT;
         col_ff       <= '0;
         row_ff       <= '0;
         off_ff       <= '0;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         scrolled_ff  <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fg_ff        <= 4'hF;
         bg_ff        <= 4'h0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         off_ff       <= off_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         scrolled_ff  <= scrolled_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && !csr_index) begin
            fg_ff <= csr_wdata;
         end
         if (csr_we && csr_index) begin
            bg_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      dst_ff      <= dst_in;
      fill_ff     <= fill_in;
      rsp_data_ff <= rsp_data_in;
   end

   tcw_cell_ram #(
      .DEPTH(NCELLS)
   ) u_cell_ram (
      .clock(clock),
      .req  (ram_req),
      .rdata(ram_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      (col_ff <= LAST_COL) && (row_ff <= LAST_ROW))
      else $error("Cursor left the screen.");

   a_offset_tracks_cursor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tcw_pkg::ST_IDLE) |-> (off_ff == AW'(row_ff * COLS + col_ff)))
      else $error("Cursor offset does not match row and column.");

   a_scroll_keeps_last_row: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tcw_pkg::ST_SCROLL) |-> (row_ff == LAST_ROW && col_ff == '0))
      else $error("Scroll started with the cursor off the last row.");

   a_drain_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tcw_pkg::ST_DRAIN) |-> pend_ff)
      else $error("Scroll drain without a pending cell.");
`endif

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer testbench
// Streams write, newline, clear, read and unused commands into the console
// core and checks every result against a cell-accurate software copy of the
// screen and cursor, over several color settings and random flow control.
// ----------------------------------------------------------------------------
module testbench;

   localparam int COLS       = 80;
   localparam int ROWS       = 25;
   localparam int NCELLS     = ROWS * COLS;
   localparam int IDLE_LIMIT = 12000;
   localparam int SETTLE     = 40;
   localparam logic CSR_FG   = 1'b0;
   localparam logic CSR_BG   = 1'b1;

   typedef struct {
      tcw_pkg::cmd_type cmd;
      logic [7:0]       ch;
      logic [5:0]       read_row;
      logic [7:0]       read_col;
   } console_cmd_type;

   typedef struct packed {
      logic [2:0]  pad;
      logic        scrolled;
      logic [13:0] offset;
      logic [5:0]  row;
      logic [7:0]  col;
      logic [15:0] cell_data;
   } console_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;  // ch, read_row, read_col
   logic [1:0]  req_tuser = '0;  // cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;       // cell_data, cursor_col, cursor_row, cursor_offset, scrolled
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic [3:0]  csr_wdata = '0;

   text_console_writer_core #(
      .COLS(COLS),
      .ROWS(ROWS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   logic [15:0]  screen [NCELLS];
   int unsigned  cur_col = 0;
   int unsigned  cur_row = 0;
   logic [3:0]   fg_color = 4'd15;
   logic [3:0]   bg_color = 4'd0;

   console_cmd_type console_backlog [$];
   console_rsp_type screen_rsp_q [$];
   int unsigned  mismatches = 0;
   bit           steady = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned draw_gap();
      int unsigned r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic advance_row(logic [15:0] blank);
      cur_row++;
      if (cur_row >= ROWS) begin
         for (int i = 0; i < NCELLS - COLS; i++) screen[i] = screen[i + COLS];
         for (int i = NCELLS - COLS; i < NCELLS; i++) screen[i] = blank;
         cur_row = ROWS - 1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic console_rsp_type console_step(console_cmd_type c);
      console_rsp_type r;
      logic [15:0]  blank;
      r     = '0;
      blank = {bg_color, fg_color, tcw_pkg::BLANK_CH};
      case (c.cmd)
         tcw_pkg::CMD_WRITE: begin
            if (c.ch == tcw_pkg::NEWLINE_CH) begin
               cur_col    = 0;
               r.scrolled = advance_row(blank);
            end else begin
               screen[cur_row * COLS + cur_col] = {bg_color, fg_color, c.ch};
               cur_col++;
               if (cur_col >= COLS) begin
                  cur_col    = 0;
                  r.scrolled = advance_row(blank);
               end
            end
         end
         tcw_pkg::CMD_CLEAR: begin
            foreach (screen[i]) screen[i] = blank;
            cur_col = 0;
            cur_row = 0;
         end
         tcw_pkg::CMD_READ: begin
            if (c.read_row < ROWS && c.read_col < COLS)
               r.cell_data = screen[c.read_row * COLS + c.read_col];
         end
         default: ;
      endcase
      r.col    = 8'(cur_col);
      r.row    = 6'(cur_row);
      r.offset = 14'(cur_row * COLS + cur_col);
      return r;
   endfunction

   task automatic report_mismatch(string field, int unsigned want, int unsigned got);
      $display("[%0t] %s differs: expected 0x%0h, got 0x%0h", $time, field, want, got);
      mismatches++;
   endtask

   // Driver.
   console_cmd_type req_held;
   int unsigned  req_gap = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_tvalid && req_tready) screen_rsp_q.push_back(console_step(req_held));
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0 || console_backlog.size() == 0) begin
               if (req_gap > 0) req_gap--;
               req_tvalid <= 1'b0;
            end else begin
               req_held = console_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {2'b00, req_held.read_col, req_held.read_row, req_held.ch};
               req_tuser  <= req_held.cmd;
               req_gap = draw_gap();
            end
         end
      end
   end

   // Monitor.
   int unsigned rsp_hold = 0;

   always @(posedge clock) begin
      console_rsp_type got;
      console_rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (screen_rsp_q.size() == 0) begin
               report_mismatch("pending result count", 0, 1);
            end else begin
               want = screen_rsp_q.pop_front();
               if (got.cell_data !== want.cell_data)
                  report_mismatch("cell_data", want.cell_data, got.cell_data);
               if (got.col !== want.col) report_mismatch("cursor_col", want.col, got.col);
               if (got.row !== want.row) report_mismatch("cursor_row", want.row, got.row);
               if (got.offset !== want.offset)
                  report_mismatch("cursor_offset", want.offset, got.offset);
               if (got.scrolled !== want.scrolled)
                  report_mismatch("scrolled", want.scrolled, got.scrolled);
            end
            rsp_hold = draw_gap();
         end else if (rsp_hold > 0) begin
            rsp_hold--;
         end
         rsp_tready <= (rsp_hold == 0);
      end
   end

   // Watchdog.
   int unsigned stuck_cycles = 0;

   always @(posedge clock) begin
      if (reset) begin
         stuck_cycles = 0;
      end else if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
         if (stuck_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   function automatic console_cmd_type make_cmd(tcw_pkg::cmd_type cmd, logic [7:0] ch,
                                                logic [5:0] row, logic [7:0] col);
      console_cmd_type c;
      c.cmd      = cmd;
      c.ch       = ch;
      c.read_row = row;
      c.read_col = col;
      return c;
   endfunction

   task automatic queue_random(int unsigned count);
      console_cmd_type c;
      int unsigned  r;
      repeat (count) begin
         c = make_cmd(tcw_pkg::CMD_WRITE, 8'($urandom_range(0, 255)),
                      6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
         r = $urandom_range(0, 999);
         if (r < 500) begin
         end else if (r < 700) begin
            c.ch = tcw_pkg::NEWLINE_CH;
         end else if (r < 940) begin
            c.cmd = tcw_pkg::CMD_READ;
            if ($urandom_range(0, 3) != 0) begin
               c.read_row = 6'($urandom_range(0, ROWS - 1));
               c.read_col = 8'($urandom_range(0, COLS - 1));
            end
         end else if (r < 985) begin
            c.cmd = tcw_pkg::CMD_NONE;
         end else begin
            c.cmd = tcw_pkg::CMD_CLEAR;
         end
         console_backlog.push_back(c);
      end
   endtask

   // A run of printable characters long enough to wrap the cursor to the next row.
   task automatic queue_long_line();
      repeat (COLS + $urandom_range(0, 10))
         console_backlog.push_back(make_cmd(tcw_pkg::CMD_WRITE,
                                            8'($urandom_range(8'h21, 8'h7E)), 0, 0));
   endtask

   task automatic wait_drained();
      while (console_backlog.size() > 0 || req_tvalid || screen_rsp_q.size() > 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic index, logic [3:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      if (index == CSR_FG) fg_color = value;
      else bg_color = value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      foreach (screen[i]) screen[i] = tcw_pkg::RESET_CELL;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      console_backlog.push_back(make_cmd(tcw_pkg::CMD_WRITE, 8'h48, 0, 0));
      console_backlog.push_back(make_cmd(tcw_pkg::CMD_WRITE, 8'h00, 0, 0));
      console_backlog.push_back(make_cmd(tcw_pkg::CMD_WRITE, 8'hFF, 0, 0));
      console_backlog.push_back(make_cmd(tcw_pkg::CMD_READ, 8'h00, 0, 0));
      console_backlog.push_back(make_cmd(tcw_pkg::CMD_READ, 8'hFF, 0, 1));
      console_backlog.push_back(make_cmd(tcw_pkg::CMD_READ, 8'h00, 0, 2));
      console_backlog.push_back(make_cmd(tcw_pkg::CMD_WRITE, tcw_pkg::NEWLINE_CH, 0, 0));
      console_backlog.push_back(make_cmd(tcw_pkg::CMD_READ, 8'h00, 0, 3));
      console_backlog.push_back(make_cmd(tcw_pkg::CMD_READ, 8'h00, 6'(ROWS - 1),
                                         8'(COLS - 1)));
      console_backlog.push_back(make_cmd(tcw_pkg::CMD_READ, 8'h00, 6'(ROWS - 1), 0));
      console_backlog.push_back(make_cmd(tcw_pkg::CMD_READ, 8'h00, 6'(ROWS), 0));
      console_backlog.push_back(make_cmd(tcw_pkg::CMD_READ, 8'h00, 0, 8'(COLS)));
      console_backlog.push_back(make_cmd(tcw_pkg::CMD_READ, 8'hFF, 6'h3F, 8'hFF));
      console_backlog.push_back(make_cmd(tcw_pkg::CMD_NONE, 8'hFF, 6'h3F, 8'hFF));
      console_backlog.push_back(make_cmd(tcw_pkg::CMD_WRITE, 8'h78, 6'h3F, 8'hFF));
      console_backlog.push_back(make_cmd(tcw_pkg::CMD_CLEAR, 8'hFF, 6'h3F, 8'hFF));
      console_backlog.push_back(make_cmd(tcw_pkg::CMD_READ, 8'h00, 0, 0));
      console_backlog.push_back(make_cmd(tcw_pkg::CMD_READ, 8'h00, 1, 0));
      queue_random(70);
      queue_long_line();
      queue_random(20);

      for (int phase = 1; phase < 6; phase++) begin
         wait_drained();
         steady = (phase % 3 == 1);
         case (phase)
            1: begin
               write_csr(CSR_FG, 4'd0);
               write_csr(CSR_BG, 4'd0);
            end
            2: begin
               write_csr(CSR_FG, 4'd15);
               write_csr(CSR_BG, 4'd15);
            end
            3: begin
               write_csr(CSR_BG, 4'd15);
               write_csr(CSR_FG, 4'd0);
            end
            default: begin
               write_csr(CSR_FG, 4'($urandom_range(0, 15)));
               write_csr(CSR_BG, 4'($urandom_range(0, 15)));
            end
         endcase
         queue_random(70);
         queue_long_line();
         queue_random(20);
      end

      wait_drained();
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
